@@ sv/assert_macros.svh @@
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/rvalu_pkg.sv @@
// ----------------------------------------------------------------------------
// rvalu_pkg: shared types and constants for the RV32IM ALU
// Operation codes, payload structs and pipeline sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package rvalu_pkg;
    localparam int XLEN = 32;
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = XLEN / DIV_STEPS_PER_STAGE;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_AND = 5'd2, OP_OR = 5'd3,
        OP_XOR = 5'd4, OP_SLL = 5'd5, OP_SRL = 5'd6, OP_SRA = 5'd7,
        OP_SLT = 5'd8, OP_SLTU = 5'd9, OP_MUL = 5'd10, OP_MULH = 5'd11,
        OP_MULHU = 5'd12, OP_MULHSU = 5'd13, OP_DIV = 5'd14, OP_DIVU = 5'd15,
        OP_REM = 5'd16, OP_REMU = 5'd17, OP_PASS = 5'd18
    } op_t;

    typedef struct packed {
        logic [4:0]        action;
        logic signed [31:0] first_operand;
        logic signed [31:0] second_register;
        logic signed [31:0] immediate_value;
        logic              use_immediate;
    } alu_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic              is_zero;
    } alu_out_t;

    // Per-item state in the divider chain
    typedef struct packed {
        logic [XLEN-1:0] quo;   // dividend shifting out, quotient shifting in
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] dsr;
        logic            neg_q;
        logic            neg_r;
    } div_state_t;
endpackage
`default_nettype wire

@@ sv/rvalu_div_stage.sv @@
// ----------------------------------------------------------------------------
// rvalu_div_stage: one slice of the restoring divider
// Performs STEPS unsigned shift-subtract steps on the incoming state.
// ----------------------------------------------------------------------------
`default_nettype none
module rvalu_div_stage
    import rvalu_pkg::*;
#(
    parameter int STEPS = DIV_STEPS_PER_STAGE
) (
    input  wire div_state_t din,
    output div_state_t      dout
);
    always_comb
    begin
        logic [XLEN:0] trial;
        dout = din;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {dout.rem, dout.quo[XLEN-1]} - {1'b0, dout.dsr};
            if (!trial[XLEN])
            begin
                dout.rem = trial[XLEN-1:0];
                dout.quo = {dout.quo[XLEN-2:0], 1'b1};
            end
            else
            begin
                dout.rem = {dout.rem[XLEN-2:0], dout.quo[XLEN-1]};
                dout.quo = {dout.quo[XLEN-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/rv32im_alu.sv @@
// ----------------------------------------------------------------------------
// rv32im_alu: pipelined RV32IM execute-stage ALU
// Path: stage 1 register, the side band and divider chain registers, then the output register.
// Throughput: one item per cycle; the 8-slice divider chain sets the depth, and
// the whole pipe holds only while the output register is full and not drained.
// Reset: rst_n async, clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32im_alu
    import rvalu_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      in_valid,
    output logic     in_ready,
    input  wire alu_in_t in_data,
    output logic     out_valid,
    input  wire      out_ready,
    output alu_out_t out_data
);
    // Global advance: the pipe moves when the output stage is empty or being
    // drained, so every stage holds together on a stall.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---- stage 1: operand select (register or immediate), op and operand registers ----
    logic            s1_valid_reg;
    logic [4:0]      s1_op_reg;
    logic [31:0]     s1_a_reg, s1_b_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= in_data.action;
            s1_a_reg  <= in_data.first_operand;
            s1_b_reg  <= in_data.use_immediate ? in_data.immediate_value
                                               : in_data.second_register;
        end
    end

    // ---- stage 2: simple ops and the multiply; divider setup ----
    logic        a_sgn, b_sgn;
    logic [32:0] ma, mb;
    logic [31:0] simple_next;
    logic        simple_sel_next;
    div_state_t  div0_next;
    always_comb
    begin
        logic [4:0] sh;
        logic       sdiv;
        sh    = s1_b_reg[4:0];
        a_sgn = (s1_op_reg == OP_MULH || s1_op_reg == OP_MULHSU) && s1_a_reg[31];
        b_sgn = (s1_op_reg == OP_MULH) && s1_b_reg[31];
        ma    = {a_sgn, s1_a_reg};
        mb    = {b_sgn, s1_b_reg};
        simple_sel_next = 1'b1;
        case (s1_op_reg) inside
            OP_SUB:  simple_next = s1_a_reg - s1_b_reg;
            OP_AND:  simple_next = s1_a_reg & s1_b_reg;
            OP_OR:   simple_next = s1_a_reg | s1_b_reg;
            OP_XOR:  simple_next = s1_a_reg ^ s1_b_reg;
            OP_SLL:  simple_next = s1_a_reg << sh;
            OP_SRL:  simple_next = s1_a_reg >> sh;
            OP_SRA:  simple_next = 32'($signed(s1_a_reg) >>> sh);
            OP_SLT:  simple_next = {31'd0, $signed(s1_a_reg) < $signed(s1_b_reg)};
            OP_SLTU: simple_next = {31'd0, s1_a_reg < s1_b_reg};
            OP_PASS: simple_next = s1_b_reg;
            OP_MUL, OP_MULH, OP_MULHU, OP_MULHSU,
            OP_DIV, OP_DIVU, OP_REM, OP_REMU:
            begin
                simple_next     = 32'd0;
                simple_sel_next = 1'b0;
            end
            default: simple_next = s1_a_reg + s1_b_reg;
        endcase
        sdiv = (s1_op_reg == OP_DIV) || (s1_op_reg == OP_REM);
        div0_next.quo   = (sdiv && s1_a_reg[31]) ? 32'(0 - s1_a_reg) : s1_a_reg;
        div0_next.dsr   = (sdiv && s1_b_reg[31]) ? 32'(0 - s1_b_reg) : s1_b_reg;
        div0_next.rem   = 32'd0;
        div0_next.neg_q = sdiv && (s1_a_reg[31] ^ s1_b_reg[31]);
        div0_next.neg_r = sdiv && s1_a_reg[31];
    end

    // Per-stage side band that rides along the divider chain
    typedef struct packed {
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;      // simple result or product word
        logic        done;     // res is final
    } side_t;

    logic [DIV_STAGES:0] dvalid_reg;   // valid bit for each side band stage
    side_t      side_reg [DIV_STAGES+1];
    div_state_t dv_reg   [DIV_STAGES+1];
    div_state_t dv_comb  [DIV_STAGES];

    logic signed [65:0] prod;
    assign prod = $signed(ma) * $signed(mb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dvalid_reg <= '0;
        else if (adv)
            dvalid_reg <= {dvalid_reg[DIV_STAGES-1:0], s1_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].op   <= s1_op_reg;
            side_reg[0].a    <= s1_a_reg;
            side_reg[0].b    <= s1_b_reg;
            side_reg[0].done <= simple_sel_next || s1_op_reg == OP_MUL ||
                                s1_op_reg == OP_MULH || s1_op_reg == OP_MULHU ||
                                s1_op_reg == OP_MULHSU;
            if (simple_sel_next)
                side_reg[0].res <= simple_next;
            else if (s1_op_reg == OP_MUL)
                side_reg[0].res <= prod[31:0];
            else
                side_reg[0].res <= prod[63:32];
            dv_reg[0] <= div0_next;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                side_reg[i].op   <= side_reg[i-1].op;
                side_reg[i].a    <= side_reg[i-1].a;
                side_reg[i].b    <= side_reg[i-1].b;
                side_reg[i].res  <= side_reg[i-1].res;
                side_reg[i].done <= side_reg[i-1].done;
                dv_reg[i]        <= dv_comb[i-1];
            end
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        rvalu_div_stage #(.STEPS(DIV_STEPS_PER_STAGE)) u_stage (
            .din  (dv_reg[g]),
            .dout (dv_comb[g])
        );
    end

    // ---- final stage: divide fix-ups, zero flag, output register ----
    side_t      sf;
    div_state_t df;
    logic [31:0] fin;
    always_comb
    begin
        logic [31:0] q, r;
        sf = side_reg[DIV_STAGES];
        df = dv_reg[DIV_STAGES];
        q  = df.neg_q ? 32'(0 - df.quo) : df.quo;
        r  = df.neg_r ? 32'(0 - df.rem) : df.rem;
        if (sf.done)
            fin = sf.res;
        else if (sf.b == 32'd0)
            fin = (sf.op == OP_DIV || sf.op == OP_DIVU) ? 32'hFFFF_FFFF : sf.a;
        else if (sf.op == OP_DIV || sf.op == OP_DIVU)
            fin = q;
        else
            fin = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= dvalid_reg[DIV_STAGES];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data.result  <= fin;
            out_data.is_zero <= (fin == 32'd0);
        end
    end
endmodule
`default_nettype wire

@@ sv/rv32im_alu_checker.sv @@
// ----------------------------------------------------------------------------
// rv32im_alu_checker: port-level checks for the ALU
// Watches the handshake and the zero flag on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rv32im_alu_checker
    import rvalu_pkg::*;
(
    input wire           clk,
    input wire           rst_n,
    input wire           in_ready,
    input wire           out_valid,
    input wire           out_ready,
    input wire alu_out_t out_data
);
    `ASSERT_IMPL(a_zero_flag, clk, rst_n, out_valid, out_data.is_zero == (out_data.result == 32'd0), "is_zero mismatch")
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output changed")
    `ASSERT_IMPL(a_ready, clk, rst_n, !out_valid || out_ready, in_ready, "input blocked with room")
endmodule

bind rv32im_alu rv32im_alu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
